// File: design/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types and constants for the periodic timer min-heap queue.
// ----------------------------------------------------------------------------
package pht_pkg;

  localparam int HEAP_DEPTH_DEF = 64;
  localparam int FIRE_LIMIT_DEF = 16;

  localparam logic [31:0] WAIT_SAT = 32'hFFFF_FFFF;
  localparam logic [32:0] ID_WRAP  = 33'h0_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_PROCESS = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_CLEARED  = 3'd4,
    ST_FIRED    = 3'd5,
    ST_NONE     = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_D,
    S_RM_LAST,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_UP,
    S_UP_P,
    S_FIRE,
    S_FIRE_X,
    S_RD_ROOT,
    S_GOT_ROOT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [48:0] deadline;
    logic [31:0] period;
    logic [31:0] ident;
  } entry_t;

  typedef struct packed {
    req_t        req;
    logic [47:0] now_ms;
    logic [31:0] interval;
    logic [31:0] timer_id;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] result_id;
    logic [6:0]  pending_count;
    logic [31:0] min_wait;
    logic        last;
  } result_t;

endpackage

// File: design/pht_ram.sv
// ----------------------------------------------------------------------------
// pht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/pht_ctrl.sv
// ----------------------------------------------------------------------------
// pht_ctrl
// Request sequencer: id scan, sift-down and sift-up over the heap RAM,
// expiry loop and result assembly.
// ----------------------------------------------------------------------------
module pht_ctrl #(
  parameter int HEAP_DEPTH = pht_pkg::HEAP_DEPTH_DEF,
  parameter int FIRE_LIMIT = pht_pkg::FIRE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pht_pkg::request_t             in_req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pht_pkg::result_t              res,
  output logic                          mem_we,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_waddr,
  output pht_pkg::entry_t               mem_wdata,
  output logic [$clog2(HEAP_DEPTH)-1:0] mem_raddr,
  input  pht_pkg::entry_t               mem_rdata
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = AW + 2;
  localparam int NW = $clog2(FIRE_LIMIT + 1);

  pht_pkg::state_t  state, state_next;
  pht_pkg::req_t    req, req_next;
  pht_pkg::status_t status, status_next;
  pht_pkg::entry_t  x, x_next;
  pht_pkg::entry_t  c, c_next;
  pht_pkg::entry_t  root, root_next;

  logic [47:0]   now_q, now_q_next;
  logic [31:0]   want, want_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   next_id, next_id_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] c_idx, c_idx_next;
  logic [CW-1:0] idx, idx_next;
  logic [31:0]   fid, fid_next;
  logic [31:0]   fper, fper_next;
  logic [NW-1:0] n, n_next;
  logic [31:0]   rid, rid_next;

  logic [KW-1:0] kid, kid_r;
  logic [AW-1:0] parent;
  logic [CW-1:0] count_m1;
  logic [48:0]   now49, diff;
  logic [32:0]   nid;
  logic [31:0]   cnt32;
  logic [31:0]   wait_v;
  logic          more;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pht_pkg::S_IDLE;
      count   <= '0;
      next_id <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    status <= status_next;
    x      <= x_next;
    c      <= c_next;
    root   <= root_next;
    now_q  <= now_q_next;
    want   <= want_next;
    pos    <= pos_next;
    c_idx  <= c_idx_next;
    idx    <= idx_next;
    fid    <= fid_next;
    fper   <= fper_next;
    n      <= n_next;
    rid    <= rid_next;
  end

  assign kid      = KW'({pos, 1'b1});
  assign kid_r    = kid + 1'b1;
  assign parent   = AW'((pos - 1'b1) >> 1);
  assign count_m1 = count - 1'b1;
  assign now49    = {1'b0, now_q};
  assign diff     = root.deadline - now49;
  assign cnt32    = 32'(count);

  always_comb begin
    if (count == '0) begin
      wait_v = pht_pkg::WAIT_SAT;
    end else if (root.deadline <= now49) begin
      wait_v = '0;
    end else if (diff[48:32] != '0) begin
      wait_v = pht_pkg::WAIT_SAT;
    end else begin
      wait_v = diff[31:0];
    end
  end

  assign more = (req == pht_pkg::REQ_PROCESS) && (status == pht_pkg::ST_FIRED) &&
                ((int'(n) + 1) < FIRE_LIMIT) && (count != '0) &&
                (root.deadline <= now49);

  assign res.status        = status;
  assign res.result_id     = rid;
  assign res.pending_count = cnt32[6:0];
  assign res.min_wait      = wait_v;
  assign res.last          = !more;

  always_comb begin
    state_next   = state;
    req_next     = req;
    status_next  = status;
    x_next       = x;
    c_next       = c;
    root_next    = root;
    now_q_next   = now_q;
    want_next    = want;
    count_next   = count;
    next_id_next = next_id;
    pos_next     = pos;
    c_idx_next   = c_idx;
    idx_next     = idx;
    fid_next     = fid;
    fper_next    = fper;
    n_next       = n;
    rid_next     = rid;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = pos;
    mem_wdata    = x;
    mem_raddr    = '0;
    nid          = {1'b0, next_id} + 33'd1;
    if (nid >= pht_pkg::ID_WRAP) begin
      nid = nid - pht_pkg::ID_WRAP;
    end

    case (state)
      pht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next   = in_req.req;
          now_q_next = in_req.now_ms;
          want_next  = in_req.timer_id;
          n_next     = '0;
          rid_next   = '0;
          case (in_req.req)
            pht_pkg::REQ_ADD: begin
              if (count >= CW'(HEAP_DEPTH)) begin
                status_next = pht_pkg::ST_FULL;
                state_next  = pht_pkg::S_RD_ROOT;
              end else begin
                next_id_next    = nid[31:0];
                x_next.deadline = {1'b0, in_req.now_ms} + 49'(in_req.interval);
                x_next.period   = in_req.interval;
                x_next.ident    = nid[31:0];
                pos_next        = count[AW-1:0];
                count_next      = count + 1'b1;
                status_next     = pht_pkg::ST_ADDED;
                rid_next        = nid[31:0];
                state_next      = pht_pkg::S_UP;
              end
            end
            pht_pkg::REQ_REMOVE: begin
              idx_next    = '0;
              status_next = pht_pkg::ST_NOTFOUND;
              state_next  = pht_pkg::S_SCAN;
            end
            pht_pkg::REQ_PROCESS: begin
              status_next = pht_pkg::ST_NONE;
              state_next  = pht_pkg::S_RD_ROOT;
            end
            default: begin
              count_next  = '0;
              status_next = pht_pkg::ST_CLEARED;
              state_next  = pht_pkg::S_RD_ROOT;
            end
          endcase
        end
      end

      pht_pkg::S_SCAN: begin
        mem_raddr = idx[AW-1:0];
        if (idx < count) begin
          state_next = pht_pkg::S_SCAN_D;
        end else begin
          state_next = pht_pkg::S_RD_ROOT;
        end
      end

      pht_pkg::S_SCAN_D: begin
        if (mem_rdata.ident == want) begin
          status_next = pht_pkg::ST_REMOVED;
          rid_next    = want;
          count_next  = count_m1;
          mem_raddr   = count_m1[AW-1:0];
          if (idx < count_m1) begin
            state_next = pht_pkg::S_RM_LAST;
          end else begin
            state_next = pht_pkg::S_RD_ROOT;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = pht_pkg::S_SCAN;
        end
      end

      pht_pkg::S_RM_LAST: begin
        x_next     = mem_rdata;
        pos_next   = idx[AW-1:0];
        state_next = pht_pkg::S_DN;
      end

      pht_pkg::S_DN: begin
        mem_raddr = kid[AW-1:0];
        if (kid < KW'(count)) begin
          state_next = pht_pkg::S_DN_L;
        end else if (req == pht_pkg::REQ_REMOVE) begin
          state_next = pht_pkg::S_UP;
        end else begin
          // hole settles, then re-arm the fired timer at the tail
          mem_we          = 1'b1;
          x_next.deadline = now49 + 49'(fper);
          x_next.period   = fper;
          x_next.ident    = fid;
          pos_next        = count[AW-1:0];
          count_next      = count + 1'b1;
          state_next      = pht_pkg::S_UP;
        end
      end

      pht_pkg::S_DN_L: begin
        c_next     = mem_rdata;
        c_idx_next = kid[AW-1:0];
        mem_raddr  = kid_r[AW-1:0];
        if (kid_r < KW'(count)) begin
          state_next = pht_pkg::S_DN_R;
        end else begin
          state_next = pht_pkg::S_DN_CMP;
        end
      end

      pht_pkg::S_DN_R: begin
        if (c.deadline > mem_rdata.deadline) begin
          c_next     = mem_rdata;
          c_idx_next = kid_r[AW-1:0];
        end
        state_next = pht_pkg::S_DN_CMP;
      end

      pht_pkg::S_DN_CMP: begin
        if (x.deadline <= c.deadline) begin
          if (req == pht_pkg::REQ_REMOVE) begin
            state_next = pht_pkg::S_UP;
          end else begin
            mem_we          = 1'b1;
            x_next.deadline = now49 + 49'(fper);
            x_next.period   = fper;
            x_next.ident    = fid;
            pos_next        = count[AW-1:0];
            count_next      = count + 1'b1;
            state_next      = pht_pkg::S_UP;
          end
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = c;
          pos_next   = c_idx;
          state_next = pht_pkg::S_DN;
        end
      end

      pht_pkg::S_UP: begin
        mem_raddr = parent;
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = pht_pkg::S_RD_ROOT;
        end else begin
          state_next = pht_pkg::S_UP_P;
        end
      end

      pht_pkg::S_UP_P: begin
        mem_we = 1'b1;
        if (mem_rdata.deadline <= x.deadline) begin
          state_next = pht_pkg::S_RD_ROOT;
        end else begin
          mem_wdata  = mem_rdata;
          pos_next   = parent;
          state_next = pht_pkg::S_UP;
        end
      end

      pht_pkg::S_FIRE: begin
        fid_next   = root.ident;
        fper_next  = root.period;
        mem_raddr  = count_m1[AW-1:0];
        state_next = pht_pkg::S_FIRE_X;
      end

      pht_pkg::S_FIRE_X: begin
        x_next      = mem_rdata;
        count_next  = count_m1;
        pos_next    = '0;
        status_next = pht_pkg::ST_FIRED;
        rid_next    = fid;
        state_next  = pht_pkg::S_DN;
      end

      pht_pkg::S_RD_ROOT: begin
        state_next = pht_pkg::S_GOT_ROOT;
      end

      pht_pkg::S_GOT_ROOT: begin
        root_next = mem_rdata;
        if (status == pht_pkg::ST_NONE && count != '0 &&
            mem_rdata.deadline <= now49) begin
          state_next = pht_pkg::S_FIRE;
        end else begin
          state_next = pht_pkg::S_EMIT;
        end
      end

      pht_pkg::S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (more) begin
            n_next     = n + 1'b1;
            state_next = pht_pkg::S_FIRE;
          end else begin
            state_next = pht_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = pht_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/periodic_timer_min_heap_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_min_heap_top
// Periodic timer queue held as a binary min-heap in one RAM.
// ----------------------------------------------------------------------------
// One request word enters on s_axis; each request gives one or more result
// words on m_axis, the final one flagged by m_axis_tlast. A process request
// gives one word per fired timer, up to FIRE_LIMIT, or one word if none fires.
// Requests are taken one at a time: s_axis_tready is high only while the
// sequencer is idle. Every heap access is a RAM read with registered read
// data, so the sift steps follow the heap height L = log2(HEAP_DEPTH):
//   add        sift-up from the tail
//   remove     id scan over the entries, then sift-down and sift-up
//   process    per fired timer: sift-down from the root, then re-arm and sift-up
//   clear      no heap walk
// Results sit in an output register; a new request is accepted while the last
// word still waits. A stalled receiver holds the sequencer before it loads the
// next word. Reset empties the queue and restarts ids at one; no RAM sweep.
// ----------------------------------------------------------------------------
module periodic_timer_min_heap_top #(
  parameter int HEAP_DEPTH = pht_pkg::HEAP_DEPTH_DEF,
  parameter int FIRE_LIMIT = pht_pkg::FIRE_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0], now_ms[49:2], interval[81:50], timer_id[113:82], zero pad
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], result_id[34:3], pending_count[41:35], min_wait[73:42], pad
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int EW = $bits(pht_pkg::entry_t);

  pht_pkg::request_t req;
  pht_pkg::result_t  res;
  logic              res_valid, res_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [EW-1:0]     mem_wdata, mem_rdata;

  assign req.req      = pht_pkg::req_t'(s_axis_tdata[1:0]);
  assign req.now_ms   = s_axis_tdata[49:2];
  assign req.interval = s_axis_tdata[81:50];
  assign req.timer_id = s_axis_tdata[113:82];

  pht_ctrl #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .FIRE_LIMIT(FIRE_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pht_ram #(
    .WIDTH(EW),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output word register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {6'd0, res.min_wait, res.pending_count, res.result_id,
                       res.status};
      m_axis_tlast <= res.last;
    end
  end

endmodule

// File: design/pht_checker.sv
// ----------------------------------------------------------------------------
// pht_checker
// Port-level checks for the periodic timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module pht_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata,
  input logic         m_axis_tlast
);

  logic [2:0] st;
  assign st = m_axis_tdata[2:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid after reset");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (st == pht_pkg::ST_FULL || st == pht_pkg::ST_NOTFOUND ||
      st == pht_pkg::ST_CLEARED || st == pht_pkg::ST_NONE)
      |-> m_axis_tdata[34:3] == 32'd0 && m_axis_tlast)
    else $error("non-firing result with id or without last");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st == pht_pkg::ST_CLEARED
      |-> m_axis_tdata[41:35] == 7'd0 && m_axis_tdata[73:42] == pht_pkg::WAIT_SAT)
    else $error("cleared queue reports entries");

endmodule

bind periodic_timer_min_heap_top pht_checker u_pht_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
